FILE: sv/alt_pkg.sv
// ----------------------------------------------------------------------------
// alt_pkg
// shared types, character codes and limits of the assembly line tokenizer
// ----------------------------------------------------------------------------
`default_nettype none

package alt_pkg;

    localparam int MAX_TOKENS = 4;
    localparam int LINE_BYTES = 4096;

    localparam int CHAR_W  = 8;
    localparam int POS_W   = 12;
    localparam int TIDX_W  = 2;
    localparam int LINE_W  = 24;
    localparam int CNT_W   = 3;
    localparam int SIZE_W  = 13;

    localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};

    // character codes
    localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_LBRK   = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_RBRK   = 8'h5D;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_TERM  = 2'd1,
        KIND_LINE  = 2'd2,
        KIND_ERROR = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ERR_COMMA     = 3'd0,
        ERR_OPEN_BRK  = 3'd1,
        ERR_CLOSE_BRK = 3'd2,
        ERR_TOKENS    = 3'd3,
        ERR_FULL      = 3'd4
    } t_err;

    typedef struct packed {
        logic              in_comment;
        logic              in_token;
        logic              esc;
        logic              in_quotes;
        logic [CHAR_W-1:0] quote_char;
        logic              in_brackets;
        logic [CNT_W-1:0]  tokens;
        logic [POS_W-1:0]  wpos;
        logic [LINE_W-1:0] line_cnt;
        logic              err_flag;
    } t_state;

    typedef struct packed {
        t_kind             kind;
        logic [CHAR_W-1:0] byte_value;
        logic [POS_W-1:0]  position;
        logic [TIDX_W-1:0] token_index;
        logic              token_start;
        logic [LINE_W-1:0] line_no;
        logic [CNT_W-1:0]  token_count;
        logic [SIZE_W-1:0] line_size;
        t_err              error_code;
        logic              errors_seen;
    } t_result;

endpackage

`default_nettype wire

FILE: sv/alt_step.sv
// ----------------------------------------------------------------------------
// alt_step
// one character of tokenizer work: next state and the optional result word
// ----------------------------------------------------------------------------
`default_nettype none

module alt_step (
    input  wire logic [alt_pkg::CHAR_W-1:0] i_char,
    input  alt_pkg::t_state                 i_state,
    output alt_pkg::t_state                 o_state,
    output logic                            o_has_result,
    output alt_pkg::t_result                o_result
);

    logic                            is_sep;
    logic                            is_quote;
    logic                            full;
    logic [alt_pkg::LINE_W-1:0]      cur_line;

    assign is_sep   = (i_char == alt_pkg::CH_SPACE) || (i_char == alt_pkg::CH_TAB) ||
                      (i_char == alt_pkg::CH_SEMI)  || (i_char == alt_pkg::CH_COMMA);
    assign is_quote = (i_char == alt_pkg::CH_DQUOTE) || (i_char == alt_pkg::CH_SQUOTE);
    // last slot stays free for the final terminator
    assign full     = (i_state.wpos == alt_pkg::POS_W'(alt_pkg::LINE_BYTES - 1));
    assign cur_line = (i_state.line_cnt != alt_pkg::LINE_MAX) ?
                      i_state.line_cnt + 1'b1 : alt_pkg::LINE_MAX;

    always_comb begin
        logic               drop;
        logic               start;
        logic               do_store;
        logic               do_report;
        alt_pkg::t_kind     store_kind;
        logic [alt_pkg::CHAR_W-1:0] store_byte;
        alt_pkg::t_err      code;

        drop       = 1'b0;
        start      = 1'b0;
        do_store   = 1'b0;
        do_report  = 1'b0;
        store_kind = alt_pkg::KIND_BYTE;
        store_byte = '0;
        code       = alt_pkg::ERR_COMMA;

        o_state      = i_state;
        o_state.esc  = 1'b0;
        o_has_result = 1'b0;
        o_result     = '0;

        if (is_sep) begin
            if (i_state.in_comment || i_state.in_brackets) begin
                drop = 1'b1;
            end else if (i_state.in_quotes) begin
                do_store   = 1'b1;
                store_byte = i_char;
            end else if (i_state.in_token) begin
                o_state.in_token = 1'b0;
                do_store         = 1'b1;
                store_kind       = alt_pkg::KIND_TERM;
            end else if (i_char == alt_pkg::CH_COMMA) begin
                do_report = 1'b1;
                code      = alt_pkg::ERR_COMMA;
            end else if (i_char == alt_pkg::CH_SEMI) begin
                o_state.in_comment = 1'b1;
            end
        end else if (i_char == alt_pkg::CH_NL) begin
            o_state.line_cnt    = cur_line;
            o_state.in_comment  = 1'b0;
            o_state.in_token    = 1'b0;
            o_state.in_brackets = 1'b0;
            if (i_state.wpos != '0) begin
                o_has_result         = 1'b1;
                o_result.kind        = alt_pkg::KIND_LINE;
                o_result.position    = i_state.wpos;
                o_result.line_no     = cur_line;
                o_result.token_count = i_state.tokens;
                o_result.line_size   = alt_pkg::SIZE_W'(i_state.wpos) + 1'b1;
                o_state.wpos         = '0;
                o_state.tokens       = '0;
            end
        end else if (!i_state.in_comment) begin
            if (i_char == alt_pkg::CH_LBRK) begin
                if (i_state.in_brackets) begin
                    do_report = 1'b1;
                    code      = alt_pkg::ERR_OPEN_BRK;
                    drop      = 1'b1;
                end else begin
                    o_state.in_brackets = 1'b1;
                end
            end else if (i_char == alt_pkg::CH_RBRK) begin
                if (!i_state.in_brackets) begin
                    do_report = 1'b1;
                    code      = alt_pkg::ERR_CLOSE_BRK;
                    drop      = 1'b1;
                end else begin
                    o_state.in_brackets = 1'b0;
                end
            end
            if (!drop && !i_state.in_token) begin
                o_state.in_token = 1'b1;
                if (int'(i_state.tokens) >= alt_pkg::MAX_TOKENS) begin
                    do_report = 1'b1;
                    code      = alt_pkg::ERR_TOKENS;
                    drop      = 1'b1;
                end else begin
                    o_state.tokens = i_state.tokens + 1'b1;
                    start          = 1'b1;
                end
            end
            if (!drop && !i_state.esc) begin
                if (i_char == alt_pkg::CH_BSLASH) begin
                    o_state.esc = 1'b1;
                    drop        = 1'b1;
                end else if (is_quote) begin
                    if (i_state.in_quotes) begin
                        if (i_char == i_state.quote_char) begin
                            o_state.in_quotes  = 1'b0;
                            o_state.quote_char = '0;
                        end
                    end else begin
                        o_state.in_quotes  = 1'b1;
                        o_state.quote_char = i_char;
                    end
                end
            end
            if (!drop) begin
                do_store   = 1'b1;
                store_byte = i_char;
            end
        end

        // a store into the reserved last slot turns into a buffer-full error
        if (do_store && full) begin
            do_report = 1'b1;
            code      = alt_pkg::ERR_FULL;
        end else if (do_store) begin
            o_has_result         = 1'b1;
            o_result.kind        = store_kind;
            o_result.byte_value  = store_byte;
            o_result.position    = i_state.wpos;
            // index follows the count after a token that opens here
            o_result.token_index = (o_state.tokens == '0) ? '0 :
                                   alt_pkg::TIDX_W'(o_state.tokens - 1'b1);
            o_result.token_start = start;
            o_result.line_no     = cur_line;
            o_state.wpos         = i_state.wpos + 1'b1;
        end

        if (do_report) begin
            o_has_result         = 1'b1;
            o_state.err_flag     = 1'b1;
            o_result.kind        = alt_pkg::KIND_ERROR;
            o_result.position    = i_state.wpos;
            o_result.line_no     = cur_line;
            o_result.error_code  = code;
        end

        o_result.errors_seen = o_state.err_flag;
    end

endmodule

`default_nettype wire

FILE: sv/assembly_line_tokenizer.sv
// ----------------------------------------------------------------------------
// assembly_line_tokenizer
// splits a stream of assembly source characters into bytes, token
// terminators, line records and error words
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                     | payload
//  ---------+-----------+-------------------------------+---------------------
//  char     | in        | i_char_valid / o_char_ready   | i_char_in
//  result   | out       | o_res_valid  / i_res_ready    | o_kind .. o_errors_seen
//
//  one character per cycle unless a result word stalls; a character waits
//  in the input register and its result word is then registered in the
//  result register. the state update is a single pass of flag logic, so
//  no loop bounds rate. reset (synchronous, active low) clears tokenizer
//  state and both valids. a stalled result word stalls the input stage only
//  when the waiting character produces a word; characters with no result drain
// ----------------------------------------------------------------------------
`default_nettype none

module assembly_line_tokenizer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // character input
    input  wire logic        i_char_valid,
    output logic             o_char_ready,
    input  wire logic [7:0]  i_char_in,
    // result output
    output logic             o_res_valid,
    input  wire logic        i_res_ready,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_byte_value,
    output logic [11:0]      o_position,
    output logic [1:0]       o_token_index,
    output logic             o_token_start,
    output logic [23:0]      o_line_no,
    output logic [2:0]       o_token_count,
    output logic [12:0]      o_line_size,
    output logic [2:0]       o_error_code,
    output logic             o_errors_seen
);

    // input register
    logic                          r_in_valid;
    logic [alt_pkg::CHAR_W-1:0]    r_char;

    // tokenizer state
    alt_pkg::t_state               r_state;
    alt_pkg::t_state               n_state;

    // result register
    logic                          r_out_valid;
    logic                          n_out_valid;
    alt_pkg::t_result              r_res;
    alt_pkg::t_result              n_res;

    logic                          has_result;
    logic                          advance;

    alt_step u_step (
        .i_char       (r_char),
        .i_state      (r_state),
        .o_state      (n_state),
        .o_has_result (has_result),
        .o_result     (n_res)
    );

    // the held character moves on when the result slot is free, is being
    // taken, or the character produces nothing
    assign advance      = r_in_valid && (!r_out_valid || i_res_ready || !has_result);
    assign o_char_ready = !r_in_valid || advance;

    always_comb begin
        if (advance && has_result) begin
            n_out_valid = 1'b1;
        end else if (i_res_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (o_char_ready) begin
                r_in_valid <= i_char_valid;
            end
            r_out_valid <= n_out_valid;
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_char_ready && i_char_valid) begin
            r_char <= i_char_in;
        end
        if (advance && has_result) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid   = r_out_valid;
    assign o_kind        = r_res.kind;
    assign o_byte_value  = r_res.byte_value;
    assign o_position    = r_res.position;
    assign o_token_index = r_res.token_index;
    assign o_token_start = r_res.token_start;
    assign o_line_no     = r_res.line_no;
    assign o_token_count = r_res.token_count;
    assign o_line_size   = r_res.line_size;
    assign o_error_code  = r_res.error_code;
    assign o_errors_seen = r_res.errors_seen;

`ifndef SYNTHESIS
    // sticky error flag never clears
    a_err_sticky : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.err_flag |=> r_state.err_flag)
        else $error("error flag cleared");

    // an error word always carries the sticky flag
    a_err_seen : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_kind == alt_pkg::KIND_ERROR)) |-> o_errors_seen)
        else $error("error word without sticky flag");

    // token count stays within the limit
    a_tok_limit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_state.tokens) <= alt_pkg::MAX_TOKENS)
        else $error("token count past limit");

    // empty input register always takes a character
    a_in_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_char_ready)
        else $error("input stalled while empty");
`endif

endmodule

`default_nettype wire
